// ===== sv/fan_heater_pwm_controller_unit_assert.svh =====
// assertion macros for the fan heater pwm controller checker
`ifndef FAN_HEATER_PWM_CONTROLLER_UNIT_ASSERT_SVH
`define FAN_HEATER_PWM_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FHPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fhpc check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define FHPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fhpc check failed");

`endif

// ===== sv/fhpc_pkg.sv =====
// shared types, codes and constants of the fan heater pwm controller
package fhpc_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_W  = 3;

  // event codes
  typedef enum logic [OP_W-1:0] {
    OP_CMD   = 2'd0,
    OP_PULSE = 2'd1,
    OP_FAN   = 2'd2,
    OP_HEAT  = 2'd3
  } op_t;

  // command characters
  localparam logic [BYTE_W-1:0] CMD_POWER  = 8'h36;
  localparam logic [BYTE_W-1:0] CMD_MODE   = 8'h37;
  localparam logic [BYTE_W-1:0] CMD_SLOWER = 8'h38;
  localparam logic [BYTE_W-1:0] CMD_FASTER = 8'h39;

  // configuration register indexes
  typedef enum logic [CFG_W-1:0] {
    CFG_SPEED_PERIOD    = 3'd0,
    CFG_REVERSAL_PULSES = 3'd1,
    CFG_HEAT_ON_TICKS   = 3'd2,
    CFG_HEAT_PERIOD     = 3'd3,
    CFG_COOL_ON_TICKS   = 3'd4,
    CFG_COOL_PERIOD     = 3'd5
  } cfg_idx_t;

  // reset values
  localparam logic [BYTE_W-1:0] RST_SPEED_PERIOD    = 8'd6;
  localparam logic [BYTE_W-1:0] RST_REVERSAL_PULSES = 8'd20;
  localparam logic [BYTE_W-1:0] RST_HEAT_ON_TICKS   = 8'd3;
  localparam logic [BYTE_W-1:0] RST_HEAT_PERIOD     = 8'd7;
  localparam logic [BYTE_W-1:0] RST_COOL_ON_TICKS   = 8'd5;
  localparam logic [BYTE_W-1:0] RST_COOL_PERIOD     = 8'd5;
  localparam logic [BYTE_W-1:0] RST_DUTY_LEVEL      = 8'd3;

  // one pwm tick: new pin level and new counter
  typedef struct packed {
    logic              pin;
    logic [BYTE_W-1:0] count;
  } pwm_step_t;

  function automatic pwm_step_t pwm_tick(input logic [BYTE_W-1:0] count,
                                         input logic [BYTE_W-1:0] on_ticks,
                                         input logic [BYTE_W-1:0] period);
    pwm_step_t         res;
    logic [BYTE_W-1:0] inc;
    res.pin   = (count < on_ticks);
    inc       = count + 8'd1;
    res.count = (inc == period) ? '0 : inc;
    return res;
  endfunction

endpackage

// ===== sv/fan_heater_pwm_controller_unit.sv =====
// fan heater pwm controller: event register, state update and result handshake
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid/in_ready   | operation, cmd_byte
//   out_    | output    | out_valid/out_ready | drives, lamp, direction, power, level
//   cfg_    | input     | cfg_valid/cfg_ready | index, data
//
// one event per cycle while results are taken: an event waits in the input
// register, then updates the state, whose registers are also the result register.
// out_valid is registered together with that state update; the out transfer
// follows once out_ready is high.
// a stalled result holds the input register; a new event is taken whenever the
// input register is empty or moves on in the same cycle.
// synchronous reset clears handshake and controller state; cfg_ready is always high.
module fan_heater_pwm_controller_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fhpc_pkg::OP_W-1:0]    in_operation,
  input  logic [fhpc_pkg::BYTE_W-1:0]  in_cmd_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_heat_drive,
  output logic                         out_fan_drive,
  output logic                         out_upper_lamp,
  output logic                         out_reverse_dir,
  output logic                         out_powered,
  output logic [fhpc_pkg::BYTE_W-1:0]  out_speed_level,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [fhpc_pkg::CFG_W-1:0]   cfg_index,
  input  logic [fhpc_pkg::BYTE_W-1:0]  cfg_data
);
  import fhpc_pkg::*;

  // input register
  logic              in_valid_r;
  op_t               op_r;
  logic [BYTE_W-1:0] cmd_r;

  // configuration registers
  logic [BYTE_W-1:0] speed_period_r, reversal_pulses_r;
  logic [BYTE_W-1:0] heat_on_ticks_r, heat_period_r;
  logic [BYTE_W-1:0] cool_on_ticks_r, cool_period_r;

  // controller state, also the result payload
  logic              out_valid_r;
  logic              power_r, cool_r, dir_r, heat_pin_r, fan_pin_r;
  logic [BYTE_W-1:0] heat_cnt_r, fan_cnt_r, duty_r, pulse_r;

  logic              power_nxt, cool_nxt, dir_nxt, heat_pin_nxt, fan_pin_nxt;
  logic [BYTE_W-1:0] heat_cnt_nxt, fan_cnt_nxt, duty_nxt, pulse_nxt;
  logic [BYTE_W-1:0] pulse_inc;
  pwm_step_t         fan_step, heat_step;
  logic              advance;

  // pipeline control
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_heat_drive  = heat_pin_r;
  assign out_fan_drive   = fan_pin_r;
  assign out_upper_lamp  = cool_r;
  assign out_reverse_dir = dir_r;
  assign out_powered     = power_r;
  assign out_speed_level = duty_r;

  // pwm and pulse arithmetic
  assign pulse_inc = pulse_r + 8'd1;
  assign fan_step  = pwm_tick(fan_cnt_r, duty_r, speed_period_r);
  assign heat_step = cool_r ? pwm_tick(heat_cnt_r, cool_on_ticks_r, cool_period_r)
                            : pwm_tick(heat_cnt_r, heat_on_ticks_r, heat_period_r);

  // state update for the event in the input register
  always_comb begin
    power_nxt    = power_r;
    cool_nxt     = cool_r;
    dir_nxt      = dir_r;
    heat_pin_nxt = heat_pin_r;
    fan_pin_nxt  = fan_pin_r;
    heat_cnt_nxt = heat_cnt_r;
    fan_cnt_nxt  = fan_cnt_r;
    duty_nxt     = duty_r;
    pulse_nxt    = pulse_r;
    case (op_r)
      OP_CMD: begin
        case (cmd_r)
          CMD_POWER: begin
            if (!power_r) begin
              power_nxt = 1'b1;
              dir_nxt   = 1'b0;
              pulse_nxt = '0;
            end else begin
              power_nxt    = 1'b0;
              heat_pin_nxt = 1'b0;
              fan_pin_nxt  = 1'b0;
            end
          end
          CMD_MODE: begin
            cool_nxt     = !cool_r;
            heat_cnt_nxt = '0;
          end
          CMD_SLOWER: begin
            if (duty_r > 8'd1) begin
              duty_nxt    = duty_r - 8'd1;
              fan_cnt_nxt = '0;
            end
          end
          CMD_FASTER: begin
            if (duty_r < speed_period_r) begin
              duty_nxt    = duty_r + 8'd1;
              fan_cnt_nxt = '0;
            end
          end
          default: begin
          end
        endcase
      end
      OP_PULSE: begin
        if (pulse_inc == reversal_pulses_r) begin
          pulse_nxt = '0;
          dir_nxt   = !dir_r;
        end else begin
          pulse_nxt = pulse_inc;
        end
      end
      OP_FAN: begin
        if (power_r) begin
          fan_pin_nxt = fan_step.pin;
          fan_cnt_nxt = fan_step.count;
        end
      end
      OP_HEAT: begin
        if (power_r) begin
          heat_pin_nxt = heat_step.pin;
          heat_cnt_nxt = heat_step.count;
        end
      end
      default: begin
      end
    endcase
  end

  // input register, state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      power_r     <= 1'b0;
      cool_r      <= 1'b0;
      dir_r       <= 1'b0;
      heat_pin_r  <= 1'b0;
      fan_pin_r   <= 1'b0;
      heat_cnt_r  <= '0;
      fan_cnt_r   <= '0;
      duty_r      <= RST_DUTY_LEVEL;
      pulse_r     <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        power_r     <= power_nxt;
        cool_r      <= cool_nxt;
        dir_r       <= dir_nxt;
        heat_pin_r  <= heat_pin_nxt;
        fan_pin_r   <= fan_pin_nxt;
        heat_cnt_r  <= heat_cnt_nxt;
        fan_cnt_r   <= fan_cnt_nxt;
        duty_r      <= duty_nxt;
        pulse_r     <= pulse_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // input payload, loaded on transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= op_t'(in_operation);
      cmd_r <= in_cmd_byte;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_period_r    <= RST_SPEED_PERIOD;
      reversal_pulses_r <= RST_REVERSAL_PULSES;
      heat_on_ticks_r   <= RST_HEAT_ON_TICKS;
      heat_period_r     <= RST_HEAT_PERIOD;
      cool_on_ticks_r   <= RST_COOL_ON_TICKS;
      cool_period_r     <= RST_COOL_PERIOD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SPEED_PERIOD:    speed_period_r    <= cfg_data;
        CFG_REVERSAL_PULSES: reversal_pulses_r <= cfg_data;
        CFG_HEAT_ON_TICKS:   heat_on_ticks_r   <= cfg_data;
        CFG_HEAT_PERIOD:     heat_period_r     <= cfg_data;
        CFG_COOL_ON_TICKS:   cool_on_ticks_r   <= cfg_data;
        CFG_COOL_PERIOD:     cool_period_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/fhpc_checker.sv =====
// port-level checks of the fan heater pwm controller and their bind
`include "fan_heater_pwm_controller_unit_assert.svh"

module fhpc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [fhpc_pkg::OP_W-1:0]    in_operation,
  input logic [fhpc_pkg::BYTE_W-1:0]  in_cmd_byte,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_heat_drive,
  input logic                         out_fan_drive,
  input logic                         out_upper_lamp,
  input logic                         out_reverse_dir,
  input logic                         out_powered,
  input logic [fhpc_pkg::BYTE_W-1:0]  out_speed_level,
  input logic                         cfg_valid,
  input logic                         cfg_ready
);
  import fhpc_pkg::*;

  logic [OP_W+BYTE_W-1:0] in_word;
  logic [BYTE_W+4:0]      out_word;

  // whole payloads of both channels
  assign in_word  = {in_operation, in_cmd_byte};
  assign out_word = {out_heat_drive, out_fan_drive, out_upper_lamp, out_reverse_dir,
                     out_powered, out_speed_level};

  // a stalled result stays offered with the same payload
  `FHPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

  // a waiting event stays offered with the same payload
  `FHPC_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_word))

  // switched off means both drives are low
  `FHPC_ASSERT_NOW(a_off_drives_low, out_valid && !out_powered, !out_heat_drive && !out_fan_drive)

  // duty level never drops to zero
  `FHPC_ASSERT_NOW(a_level_nonzero, out_valid, out_speed_level != '0)

  // register writes are never held off
  `FHPC_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind fan_heater_pwm_controller_unit fhpc_checker u_fhpc_checker (.*);

// ===== tb/testbench.sv =====
// self-checking testbench for the fan heater pwm controller unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fhpc_pkg::*;

  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned PHASES       = 7;
  localparam int unsigned PHASE_EVENTS = 62;
  localparam int unsigned HOLD_CYCLES  = 48;
  localparam int unsigned TAIL_CYCLES  = 10;
  localparam int unsigned DIR_ROWS     = 24;

  // pin levels and status after one event
  typedef struct packed {
    logic              heat;
    logic              fan;
    logic              lamp;
    logic              dir;
    logic              pwr;
    logic [BYTE_W-1:0] level;
  } status_t;

  // one directed event, with its status typed in where it is obvious
  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] cmd;
    logic              typed;
    status_t           want;
  } row_t;

  // one full register setting
  typedef struct packed {
    logic [BYTE_W-1:0] fan_per;
    logic [BYTE_W-1:0] rev;
    logic [BYTE_W-1:0] h_on;
    logic [BYTE_W-1:0] h_per;
    logic [BYTE_W-1:0] c_on;
    logic [BYTE_W-1:0] c_per;
  } setting_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   in_operation = '0;
  logic [BYTE_W-1:0] in_cmd_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_heat_drive;
  logic              out_fan_drive;
  logic              out_upper_lamp;
  logic              out_reverse_dir;
  logic              out_powered;
  logic [BYTE_W-1:0] out_speed_level;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_index = '0;
  logic [BYTE_W-1:0] cfg_data = '0;

  // predicted controller registers
  logic [BYTE_W-1:0] fan_per   = RST_SPEED_PERIOD;
  logic [BYTE_W-1:0] rev_limit = RST_REVERSAL_PULSES;
  logic [BYTE_W-1:0] heat_on   = RST_HEAT_ON_TICKS;
  logic [BYTE_W-1:0] heat_per  = RST_HEAT_PERIOD;
  logic [BYTE_W-1:0] cool_on   = RST_COOL_ON_TICKS;
  logic [BYTE_W-1:0] cool_per  = RST_COOL_PERIOD;

  // predicted controller state
  logic              pwr_on   = 1'b0;
  logic              cool_sel = 1'b0;
  logic              rev_dir  = 1'b0;
  logic              heat_lvl = 1'b0;
  logic              fan_lvl  = 1'b0;
  logic [BYTE_W-1:0] heat_cnt = '0;
  logic [BYTE_W-1:0] fan_cnt  = '0;
  logic [BYTE_W-1:0] duty     = RST_DUTY_LEVEL;
  logic [BYTE_W-1:0] rev_cnt  = '0;

  status_t status_q[$];
  int      events_sent  = 0;
  int      results_seen = 0;
  int      fail_count   = 0;
  bit      calm         = 1'b0;
  bit      long_hold    = 1'b0;

  fan_heater_pwm_controller_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_cmd_byte     (in_cmd_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_heat_drive  (out_heat_drive),
    .out_fan_drive   (out_fan_drive),
    .out_upper_lamp  (out_upper_lamp),
    .out_reverse_dir (out_reverse_dir),
    .out_powered     (out_powered),
    .out_speed_level (out_speed_level),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // one counted pwm step: pin from the old count, then count with wrap at period
  task automatic pwm_advance(inout logic [BYTE_W-1:0] cnt, output logic pin,
                             input logic [BYTE_W-1:0] on_ticks,
                             input logic [BYTE_W-1:0] period);
    pin = (cnt < on_ticks);
    cnt = cnt + 8'd1;
    if (cnt == period) begin
      cnt = '0;
    end
  endtask

  // advance the predicted controller by one event and return its status
  task automatic climate_step(input op_t op, input logic [BYTE_W-1:0] cmd,
                              output status_t res);
    case (op)
      OP_CMD: begin
        case (cmd)
          CMD_POWER: begin
            if (!pwr_on) begin
              pwr_on  = 1'b1;
              rev_dir = 1'b0;
              rev_cnt = '0;
            end else begin
              pwr_on   = 1'b0;
              heat_lvl = 1'b0;
              fan_lvl  = 1'b0;
            end
          end
          CMD_MODE: begin
            cool_sel = ~cool_sel;
            heat_cnt = '0;
          end
          CMD_SLOWER: begin
            if (duty > 8'd1) begin
              duty    = duty - 8'd1;
              fan_cnt = '0;
            end
          end
          CMD_FASTER: begin
            if (duty < fan_per) begin
              duty    = duty + 8'd1;
              fan_cnt = '0;
            end
          end
          default: ;
        endcase
      end
      OP_PULSE: begin
        rev_cnt = rev_cnt + 8'd1;
        if (rev_cnt == rev_limit) begin
          rev_cnt = '0;
          rev_dir = ~rev_dir;
        end
      end
      OP_FAN: begin
        if (pwr_on) pwm_advance(fan_cnt, fan_lvl, duty, fan_per);
      end
      default: begin
        if (pwr_on) begin
          if (cool_sel) pwm_advance(heat_cnt, heat_lvl, cool_on, cool_per);
          else pwm_advance(heat_cnt, heat_lvl, heat_on, heat_per);
        end
      end
    endcase
    res = '{heat: heat_lvl, fan: fan_lvl, lamp: cool_sel, dir: rev_dir, pwr: pwr_on,
            level: duty};
  endtask

  // offer one event, optionally after an idle burst, and log its status on transfer
  task automatic send_event(input op_t op, input logic [BYTE_W-1:0] cmd,
                            input logic typed, input status_t want);
    status_t pred;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_cmd_byte  <= cmd;
    do @(posedge clk); while (!in_ready);
    climate_step(op, cmd, pred);
    status_q.push_back(typed ? want : pred);
    events_sent++;
  endtask

  // register write; cfg_valid stays high across back-to-back writes
  task automatic put_reg(input cfg_idx_t idx, input logic [BYTE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SPEED_PERIOD:    fan_per   = data;
      CFG_REVERSAL_PULSES: rev_limit = data;
      CFG_HEAT_ON_TICKS:   heat_on   = data;
      CFG_HEAT_PERIOD:     heat_per  = data;
      CFG_COOL_ON_TICKS:   cool_on   = data;
      default:             cool_per  = data;
    endcase
  endtask

  task automatic apply_setting(input setting_t s);
    put_reg(CFG_SPEED_PERIOD, s.fan_per);
    put_reg(CFG_REVERSAL_PULSES, s.rev);
    put_reg(CFG_HEAT_ON_TICKS, s.h_on);
    put_reg(CFG_HEAT_PERIOD, s.h_per);
    put_reg(CFG_COOL_ON_TICKS, s.c_on);
    put_reg(CFG_COOL_PERIOD, s.c_per);
    cfg_valid <= 1'b0;
  endtask

  function automatic setting_t rand_setting();
    setting_t s;
    s.fan_per = BYTE_W'($urandom_range(1, 12));
    s.rev     = BYTE_W'($urandom_range(1, 8));
    s.h_per   = BYTE_W'($urandom_range(1, 10));
    s.h_on    = BYTE_W'($urandom_range(0, s.h_per + 1));
    s.c_per   = BYTE_W'($urandom_range(1, 10));
    s.c_on    = BYTE_W'($urandom_range(0, s.c_per + 1));
    return s;
  endfunction

  // mostly ticks and pulses, commands weighted toward duty steps, some junk bytes
  task automatic rand_event(output op_t op, output logic [BYTE_W-1:0] cmd);
    int unsigned r;
    int unsigned pick;
    r   = $urandom_range(0, 99);
    cmd = BYTE_W'($urandom_range(0, 255));
    if (r < 30) op = OP_FAN;
    else if (r < 55) op = OP_HEAT;
    else if (r < 70) op = OP_PULSE;
    else begin
      op   = OP_CMD;
      pick = $urandom_range(0, 9);
      if (pick == 0) cmd = CMD_POWER;
      else if (pick < 3) cmd = CMD_MODE;
      else if (pick < 6) cmd = CMD_SLOWER;
      else if (pick < 9) cmd = CMD_FASTER;
    end
  endtask

  task automatic wait_drained();
    while (status_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // result side: compare every transfer with the oldest predicted status
  always @(posedge clk) begin
    status_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (status_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual level %0d", $time,
                 out_speed_level);
        fail_count++;
      end else begin
        want = status_q.pop_front();
        check_field("heat_drive", want.heat, out_heat_drive);
        check_field("fan_drive", want.fan, out_fan_drive);
        check_field("upper_lamp", want.lamp, out_upper_lamp);
        check_field("reverse_dir", want.dir, out_reverse_dir);
        check_field("powered", want.pwr, out_powered);
        check_field("speed_level", want.level, out_speed_level);
      end
    end
  end

  // receiver: random stall bursts, one long hold-off on request, none when calm
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // run time limit
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // main sequence: reset, directed table, then randomized register phases
  initial begin
    row_t              steps [DIR_ROWS];
    setting_t          phase_cfg [PHASES];
    op_t               op;
    logic [BYTE_W-1:0] cmd;

    steps = '{
      // idle controller ignores ticks, pulses and unknown bytes
      '{OP_HEAT,  8'h00,      1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd3}},
      '{OP_FAN,   8'hFF,      1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd3}},
      '{OP_PULSE, 8'hA5,      1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd3}},
      '{OP_CMD,   8'h00,      1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd3}},
      '{OP_CMD,   8'hFF,      1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd3}},
      // duty steps down to the floor of one
      '{OP_CMD,   CMD_SLOWER, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd2}},
      '{OP_CMD,   CMD_SLOWER, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd1}},
      '{OP_CMD,   CMD_SLOWER, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd1}},
      // power on, fan pwm at the lowest duty
      '{OP_CMD,   CMD_POWER,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'd1}},
      '{OP_FAN,   8'h5A,      1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'd1}},
      '{OP_FAN,   8'h00,      1'b0, '0},
      // cool mode with its always-on heater setting
      '{OP_CMD,   CMD_MODE,   1'b0, '0},
      '{OP_HEAT,  8'hC3,      1'b0, '0},
      '{OP_HEAT,  8'h3C,      1'b0, '0},
      // duty steps up to the fan period and stops there
      '{OP_CMD,   CMD_FASTER, 1'b0, '0},
      '{OP_CMD,   CMD_FASTER, 1'b0, '0},
      '{OP_CMD,   CMD_FASTER, 1'b0, '0},
      '{OP_CMD,   CMD_FASTER, 1'b0, '0},
      '{OP_CMD,   CMD_FASTER, 1'b0, '0},
      '{OP_CMD,   CMD_FASTER, 1'b0, '0},
      '{OP_FAN,   8'h11,      1'b0, '0},
      // back to heat mode, then power off drops both drives
      '{OP_CMD,   CMD_MODE,   1'b0, '0},
      '{OP_HEAT,  8'hEE,      1'b0, '0},
      '{OP_CMD,   CMD_POWER,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd6}}
    };

    // lowest, highest, random, zero periods and threshold, reset-like, random
    phase_cfg[0] = '{8'd1, 8'd1, 8'd0, 8'd1, 8'd0, 8'd1};
    phase_cfg[1] = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
    phase_cfg[2] = rand_setting();
    phase_cfg[3] = '{8'd4, 8'd0, 8'd2, 8'd0, 8'd9, 8'd3};
    phase_cfg[4] = '{RST_SPEED_PERIOD, RST_REVERSAL_PULSES, RST_HEAT_ON_TICKS,
                     RST_HEAT_PERIOD, RST_COOL_ON_TICKS, RST_COOL_PERIOD};
    phase_cfg[5] = rand_setting();
    phase_cfg[6] = rand_setting();

    // synchronous reset
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at reset register values
    foreach (steps[i]) begin
      send_event(steps[i].op, steps[i].cmd, steps[i].typed, steps[i].want);
    end
    in_valid <= 1'b0;

    // register phases, the last one without any idling
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      if (p == PHASES - 1) calm = 1'b1;
      apply_setting(phase_cfg[p]);
      if (!pwr_on) send_event(OP_CMD, CMD_POWER, 1'b0, '0);
      for (int n = 0; n < PHASE_EVENTS; n++) begin
        if (p == 3 && n == 20) long_hold = 1'b1;
        rand_event(op, cmd);
        send_event(op, cmd, 1'b0, '0);
      end
      in_valid <= 1'b0;
    end

    // drain and let any stray result show up
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d events over %0d register settings plus reset values",
             events_sent, PHASES);
    $display("%0d results compared, %0d field mismatches", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
